FILE: src/ilsc_pkg.sv
// Package for the INI line syntax checker.
// Holds the line flag type, the error codes and the character constants.
// No dependencies.
package ilsc_pkg;

  localparam int LINE_BITS_DEF = 16;
  localparam int LINE_NUM_W    = 16;
  localparam int CHAR_W        = 8;
  localparam int SKIP_W        = 2;
  localparam int IERR_W        = 3;
  localparam int EERR_W        = 2;

  localparam logic [SKIP_W-1:0] SKIP_RESET = 2'd3;

  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;  // ';'
  localparam logic [CHAR_W-1:0] CH_LBRK   = 8'h5B;  // '['
  localparam logic [CHAR_W-1:0] CH_RBRK   = 8'h5D;  // ']'
  localparam logic [CHAR_W-1:0] CH_EQUALS = 8'h3D;  // '='
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;  // ' '

  localparam logic [IERR_W-1:0] IERR_NONE         = 3'd0;
  localparam logic [IERR_W-1:0] IERR_AFTER_CLOSE  = 3'd1;
  localparam logic [IERR_W-1:0] IERR_DOUBLE_OPEN  = 3'd2;
  localparam logic [IERR_W-1:0] IERR_BEFORE_OPEN  = 3'd3;
  localparam logic [IERR_W-1:0] IERR_STRAY_CLOSE  = 3'd4;
  localparam logic [IERR_W-1:0] IERR_DOUBLE_EQ    = 3'd5;
  localparam logic [IERR_W-1:0] IERR_EQ_IN_SECT   = 3'd6;
  localparam logic [IERR_W-1:0] IERR_EMPTY_NAME   = 3'd7;

  localparam logic [EERR_W-1:0] EERR_NONE         = 2'd0;
  localparam logic [EERR_W-1:0] EERR_OPEN_BRACKET = 2'd1;
  localparam logic [EERR_W-1:0] EERR_NO_EQUALS    = 2'd2;

  typedef struct packed {
    logic cmt;       // comment seen
    logic brk;       // bracket open
    logic eol;       // only spaces may follow
    logic asg;       // '=' seen
    logic var_line;  // line may still be a variable line
    logic nsp;       // non-space seen
  } line_flags_t;

  localparam line_flags_t FLAGS_CLEAR = '{cmt: 1'b0, brk: 1'b0, eol: 1'b0, asg: 1'b0,
                                          var_line: 1'b1, nsp: 1'b0};

endpackage

FILE: src/ilsc_byte_step.sv
// Per-byte flag update of the INI line syntax checker.
// Pure combinational; depends on ilsc_pkg.
module ilsc_byte_step (
  input  ilsc_pkg::line_flags_t               flags,
  input  logic [ilsc_pkg::CHAR_W-1:0]         char_byte,
  output ilsc_pkg::line_flags_t               flags_nxt,
  output logic [ilsc_pkg::IERR_W-1:0]         err
);

  ilsc_pkg::line_flags_t f;

  always_comb begin
    f   = flags;
    err = ilsc_pkg::IERR_NONE;
    if (char_byte == ilsc_pkg::CH_SEMI) begin
      f.cmt = 1'b1;
      if (!f.nsp && !f.asg) begin
        f.var_line = 1'b0;
      end
    end
    if (f.eol && !f.cmt && char_byte != ilsc_pkg::CH_SPACE) begin
      err = ilsc_pkg::IERR_AFTER_CLOSE;
    end else if (char_byte == ilsc_pkg::CH_LBRK) begin
      if (f.brk) begin
        err = ilsc_pkg::IERR_DOUBLE_OPEN;
      end else if (f.nsp) begin
        err = ilsc_pkg::IERR_BEFORE_OPEN;
      end else begin
        f.brk      = 1'b1;
        f.var_line = 1'b0;
      end
    end else if (char_byte == ilsc_pkg::CH_RBRK) begin
      if (f.brk) begin
        f.brk = 1'b0;
        f.eol = 1'b1;
      end else begin
        err = ilsc_pkg::IERR_STRAY_CLOSE;
      end
    end else if (char_byte == ilsc_pkg::CH_EQUALS) begin
      // The empty-name test sees the name flag before '=' clears it.
      if (f.asg) begin
        err = ilsc_pkg::IERR_DOUBLE_EQ;
      end else if (f.brk) begin
        err = ilsc_pkg::IERR_EQ_IN_SECT;
      end else if (!f.nsp) begin
        err = ilsc_pkg::IERR_EMPTY_NAME;
      end else begin
        f.asg = 1'b1;
        f.nsp = 1'b0;
      end
    end else begin
      if (f.var_line && !f.nsp && char_byte != ilsc_pkg::CH_SPACE) begin
        f.nsp = 1'b1;
      end
    end
    flags_nxt = f;
  end

endmodule

FILE: src/ilsc_line_close.sv
// End-of-line checks of the INI line syntax checker.
// Pure combinational; depends on ilsc_pkg.
module ilsc_line_close (
  input  ilsc_pkg::line_flags_t         flags,
  output logic [ilsc_pkg::EERR_W-1:0]   end_error,
  output logic                          unassigned_warning
);

  always_comb begin
    // A missing '=' takes priority over an open bracket.
    if (flags.nsp && flags.var_line && !flags.asg) begin
      end_error = ilsc_pkg::EERR_NO_EQUALS;
    end else if (flags.brk) begin
      end_error = ilsc_pkg::EERR_OPEN_BRACKET;
    end else begin
      end_error = ilsc_pkg::EERR_NONE;
    end
    unassigned_warning = flags.asg && !flags.nsp;
  end

endmodule

FILE: src/ini_line_syntax_checker.sv
// Top level of the INI line syntax checker.
// Depends on ilsc_pkg, ilsc_byte_step and ilsc_line_close.
//
// Takes one text word per cycle while in_ready is high. A word is held in an
// input register, the line state is updated from it when it leaves that
// register, and a line-end word leaves one result in the output register.
// A result is presented from the output register until out_ready takes it.
// The output register lets a new word be taken while a result waits; input
// stalls only when a line-end word finds the output register still full.
// After reset three leading words are dropped without a result, and after a
// write of cfg_wdata that many. The line counter is LINE_BITS wide and
// saturates; out_line_number shows its low 16 bits.
module ini_line_syntax_checker #(
  parameter int LINE_BITS = ilsc_pkg::LINE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ilsc_pkg::CHAR_W-1:0]       in_char_byte,
  input  logic                              in_line_end,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ilsc_pkg::LINE_NUM_W-1:0]   out_line_number,
  output logic [ilsc_pkg::IERR_W-1:0]       out_inline_error,
  output logic [ilsc_pkg::EERR_W-1:0]       out_end_error,
  output logic                              out_unassigned_warning,
  output logic                              out_file_valid,
  input  logic                              cfg_we,
  input  logic [ilsc_pkg::SKIP_W-1:0]       cfg_wdata
);

  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  logic                                stage_v_r;
  logic [ilsc_pkg::CHAR_W-1:0]         stage_char_r;
  logic                                stage_le_r;

  logic [ilsc_pkg::SKIP_W-1:0]         skip_left_r;
  logic [LINE_BITS-1:0]                line_count_r;
  logic [LINE_BITS-1:0]                line_count_nxt;
  ilsc_pkg::line_flags_t               flags_r;
  logic                                frozen_r;
  logic [ilsc_pkg::IERR_W-1:0]         err_r;
  logic                                valid_so_far_r;
  logic                                valid_so_far_nxt;

  logic                                out_v_r;
  logic [ilsc_pkg::LINE_NUM_W-1:0]     out_line_r;
  logic [ilsc_pkg::IERR_W-1:0]         out_ierr_r;
  logic [ilsc_pkg::EERR_W-1:0]         out_eerr_r;
  logic                                out_warn_r;
  logic                                out_fv_r;

  ilsc_pkg::line_flags_t               step_flags;
  logic [ilsc_pkg::IERR_W-1:0]         step_err;
  logic [ilsc_pkg::EERR_W-1:0]         close_eerr;
  logic                                close_warn;
  logic [LINE_BITS+ilsc_pkg::LINE_NUM_W-1:0] line_ext;

  logic skipping;
  logic produces;
  logic advance;

  ilsc_byte_step u_byte_step (
    .flags     (flags_r),
    .char_byte (stage_char_r),
    .flags_nxt (step_flags),
    .err       (step_err)
  );

  ilsc_line_close u_line_close (
    .flags              (flags_r),
    .end_error          (close_eerr),
    .unassigned_warning (close_warn)
  );

  assign skipping = skip_left_r != '0;
  assign produces = stage_v_r && !skipping && stage_le_r;
  assign advance  = stage_v_r && (!produces || !out_v_r || out_ready);
  assign in_ready = !stage_v_r || advance;

  assign line_count_nxt   = (line_count_r == LINE_MAX) ? line_count_r
                                                       : line_count_r + 1'b1;
  assign line_ext         = {{ilsc_pkg::LINE_NUM_W{1'b0}}, line_count_nxt};
  assign valid_so_far_nxt = valid_so_far_r && err_r == ilsc_pkg::IERR_NONE &&
                            close_eerr == ilsc_pkg::EERR_NONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r      <= 1'b0;
      skip_left_r    <= ilsc_pkg::SKIP_RESET;
      line_count_r   <= '0;
      flags_r        <= ilsc_pkg::FLAGS_CLEAR;
      frozen_r       <= 1'b0;
      err_r          <= ilsc_pkg::IERR_NONE;
      valid_so_far_r <= 1'b1;
      out_v_r        <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        stage_v_r    <= 1'b1;
        stage_char_r <= in_char_byte;
        stage_le_r   <= in_line_end;
      end else if (advance) begin
        stage_v_r <= 1'b0;
      end

      if (advance && produces) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end

      if (advance) begin
        if (skipping) begin
          skip_left_r <= skip_left_r - 1'b1;
        end else if (!stage_le_r) begin
          // Bytes after an error or a comment leave the line state alone.
          if (!frozen_r && !flags_r.cmt) begin
            flags_r <= step_flags;
            if (step_err != ilsc_pkg::IERR_NONE) begin
              frozen_r <= 1'b1;
              err_r    <= step_err;
            end
          end
        end else begin
          line_count_r   <= line_count_nxt;
          valid_so_far_r <= valid_so_far_nxt;
          out_line_r     <= line_ext[ilsc_pkg::LINE_NUM_W-1:0];
          out_ierr_r     <= err_r;
          out_eerr_r     <= close_eerr;
          out_warn_r     <= close_warn;
          out_fv_r       <= valid_so_far_nxt;
          flags_r        <= ilsc_pkg::FLAGS_CLEAR;
          frozen_r       <= 1'b0;
          err_r          <= ilsc_pkg::IERR_NONE;
        end
      end

      if (cfg_we) begin
        skip_left_r <= cfg_wdata;
      end
    end
  end

  assign out_valid              = out_v_r;
  assign out_line_number        = out_line_r;
  assign out_inline_error       = out_ierr_r;
  assign out_end_error          = out_eerr_r;
  assign out_unassigned_warning = out_warn_r;
  assign out_file_valid         = out_fv_r;

endmodule
